FILE: rtl/rlt_pkg.sv
package rlt_pkg;
	localparam int DEF_ENTRIES = 64;
	localparam logic [1:0] KIND_CHECK   = 2'd0;
	localparam logic [1:0] KIND_ACQUIRE = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_REL_ALL = 2'd3;
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [19:0] NS_PER_MS = 20'd1000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] now;
		logic [63:0] file;
		logic [63:0] client;
		logic [31:0] stripe;
		logic [31:0] device;
		logic [63:0] start;
		logic [63:0] len;
		logic [31:0] dur;
	} req_t;

	typedef struct packed {
		logic [63:0] file;
		logic [63:0] client;
		logic [31:0] stripe;
		logic [31:0] device;
		logic [63:0] start;
		logic [63:0] len;
		logic [63:0] expiry;
	} lease_t;

	function automatic logic [63:0] sat_end(input logic [63:0] s, input logic [63:0] l);
		logic [64:0] e;
		e = {1'b0, s} + {1'b0, l};
		return e[64] ? '1 : e[63:0];
	endfunction
endpackage

FILE: rtl/range_lease_table.sv
// range lease table: one request transfer in, one result transfer out. the leases
// live in a synchronous memory (registered read) plus a flip-flop used bit per
// entry. every request but a zero-length check or an invalid acquire walks the
// whole table one entry a cycle; acquire then adds a write state. an invalid
// acquire or zero-length check skips the scan. one request is in flight at a time
// and the next request is taken only once the result has transferred, in the cycle
// after that transfer at the earliest.
// s_tdata bits from lsb: current_time, file_key, client_key, stripe_number,
// device_number, range_start, range_length, duration_msec; s_tuser = kind.
// m_tdata: status[1:0], conflict[2].
module range_lease_table #(
	parameter int TABLE_ENTRIES = rlt_pkg::DEF_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [415:0] s_tdata, // current_time, file, client, stripe, device, start, length, duration
	input  logic [1:0]   s_tuser, // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata  // status, conflict
);
	import rlt_pkg::*;
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_SCAN = 3'd2,
		S_WRITE = 3'd3, S_RESULT = 3'd4;

	lease_t mem [TABLE_ENTRIES];
	lease_t rd_q;
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [2:0] state_q;
	req_t req_q;
	logic [AW:0] addr_q;      // issued read address
	logic [AW-1:0] eval_idx_q; // entry whose data is in rd_q
	logic eval_v_q;
	logic [63:0] exp_q;
	logic [51:0] prod_q;
	logic found_q, slot_v_q, hit_q;
	logic [AW-1:0] found_idx_q, slot_q;
	logic [1:0] res_status_q;
	logic res_conf_q;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	lease_t wr_data;

	assign s_tready = (state_q == S_IDLE) && !m_tvalid;
	assign m_tdata = {5'd0, res_conf_q, res_status_q};

	// entry evaluation
	logic e_used, e_live, e_key, e_full;
	always_comb begin
		e_used = eval_v_q && used_q[eval_idx_q];
		e_live = rd_q.expiry > req_q.now;
		e_full = rd_q.file == req_q.file && rd_q.client == req_q.client &&
			rd_q.stripe == req_q.stripe && rd_q.start == req_q.start;
		e_key = rd_q.file == req_q.file && rd_q.stripe == req_q.stripe &&
			rd_q.client != req_q.client &&
			rd_q.start < sat_end(req_q.start, req_q.len) &&
			req_q.start < sat_end(rd_q.start, rd_q.len);
	end

	logic [64:0] exp_add;
	assign exp_add = {1'b0, req_q.now} + {13'd0, prod_q};

	always_comb begin
		wr_en = 1'b0;
		wr_addr = found_q ? found_idx_q : slot_q;
		wr_data = '{file: req_q.file, client: req_q.client, stripe: req_q.stripe,
			device: req_q.device, start: req_q.start, len: req_q.len, expiry: exp_q};
		if (state_q == S_WRITE && (found_q || slot_v_q)) wr_en = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		prod_q <= 52'(req_q.dur) * 52'(NS_PER_MS);
		if (s_tvalid && s_tready) req_q <= '{kind: s_tuser, now: s_tdata[63:0],
			file: s_tdata[127:64], client: s_tdata[191:128], stripe: s_tdata[223:192],
			device: s_tdata[255:224], start: s_tdata[319:256], len: s_tdata[383:320],
			dur: s_tdata[415:384]};
		// product settles in prep, expiry is taken during the scan
		if (state_q == S_SCAN) exp_q <= exp_add[64] ? '1 : exp_add[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			m_tvalid <= 1'b0;
			addr_q <= '0;
			eval_idx_q <= '0;
			eval_v_q <= 1'b0;
			found_q <= 1'b0;
			slot_v_q <= 1'b0;
			hit_q <= 1'b0;
			found_idx_q <= '0;
			slot_q <= '0;
			res_status_q <= ST_DONE;
			res_conf_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) state_q <= S_PREP;
					addr_q <= '0;
					eval_v_q <= 1'b0;
					found_q <= 1'b0;
					slot_v_q <= 1'b0;
					hit_q <= 1'b0;
				end
				S_PREP: begin
					// zero-length check and invalid acquire skip the scan
					if ((req_q.kind == KIND_CHECK && req_q.len == '0)) begin
						res_status_q <= ST_DONE;
						res_conf_q <= 1'b0;
						state_q <= S_RESULT;
					end else if (req_q.kind == KIND_ACQUIRE &&
						(req_q.len == '0 || req_q.dur == '0)) begin
						res_status_q <= ST_INVALID;
						res_conf_q <= 1'b0;
						state_q <= S_RESULT;
					end else begin
						addr_q <= addr_q + 1'b1;
						eval_idx_q <= '0;
						eval_v_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q < (AW+1)'(TABLE_ENTRIES)) begin
						addr_q <= addr_q + 1'b1;
						eval_idx_q <= addr_q[AW-1:0];
						eval_v_q <= 1'b1;
					end else begin
						eval_v_q <= 1'b0;
					end
					if (e_used) begin
						priority case (req_q.kind)
							KIND_CHECK: begin
								if (!e_live) used_q[eval_idx_q] <= 1'b0;
								else if (e_key) hit_q <= 1'b1;
							end
							KIND_ACQUIRE: begin
								if (!e_live) begin
									used_q[eval_idx_q] <= 1'b0;
									if (!slot_v_q && !found_q) begin
										slot_v_q <= 1'b1;
										slot_q <= eval_idx_q;
									end
								end else if (e_full && !found_q) begin
									found_q <= 1'b1;
									found_idx_q <= eval_idx_q;
								end
							end
							KIND_RELEASE: begin
								if (e_full && !found_q) begin
									found_q <= 1'b1;
									used_q[eval_idx_q] <= 1'b0;
								end
							end
							default: begin
								if (rd_q.file == req_q.file && rd_q.client == req_q.client)
									used_q[eval_idx_q] <= 1'b0;
							end
						endcase
					end else if (eval_v_q && req_q.kind == KIND_ACQUIRE && !slot_v_q &&
						!found_q) begin
						slot_v_q <= 1'b1;
						slot_q <= eval_idx_q;
					end
					if (!eval_v_q && addr_q == (AW+1)'(TABLE_ENTRIES)) begin
						res_conf_q <= hit_q && req_q.kind == KIND_CHECK;
						res_status_q <= ST_DONE;
						state_q <= (req_q.kind == KIND_ACQUIRE) ? S_WRITE : S_RESULT;
					end
				end
				S_WRITE: begin
					if (found_q) begin
						used_q[found_idx_q] <= 1'b1;
					end else if (slot_v_q) begin
						used_q[slot_q] <= 1'b1;
					end else begin
						res_status_q <= ST_FULL;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					m_tvalid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !m_tvalid) else $error("accept while result pending");
	a_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> state_q == S_IDLE) else $error("result outside idle");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_status_q != 2'd3) else $error("bad status");
	a_conf_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_conf_q) |-> res_status_q == ST_DONE) else $error("conflict with error");
endmodule
